// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame rate monitor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/frm_pkg.sv =====
// ----------------------------------------------------------------------------
// frm_pkg
// Widths, constants and shared types of the frame rate monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frm_pkg;

    // Field and counter widths.
    localparam int RATE_W    = 8;
    localparam int CNT_W     = 32;
    localparam int ELAPSED_W = 40;
    localparam int FPS_W     = 16;
    localparam int FT_W      = 20;
    localparam int FRAC_BITS = 8;

    // Shared multiplier and divider widths.
    localparam int MUL_A_W   = CNT_W + 1;
    localparam int MUL_B_W   = 20;
    localparam int NUM_W     = MUL_A_W + MUL_B_W;
    localparam int DEN_W     = CNT_W + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    // Constants.
    localparam logic [MUL_B_W-1:0] US_PER_SEC   = 20'd1000000;
    localparam logic [RATE_W-1:0]  DEFAULT_RATE = 8'd60;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_FINISH
    } t_state;

    // Quantity being computed by the shared multiplier and divider.
    typedef enum logic [1:0] {
        OP_EL,
        OP_CUR,
        OP_AVG,
        OP_FT
    } t_op;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hw/rtl/frame_rate_monitor.sv =====
// ----------------------------------------------------------------------------
// frame_rate_monitor
// Per-frame rate statistics: elapsed time, windowed fps, average fps and
// the display time of each unique frame.
//
// Input channel: one transfer per captured frame carrying its uniqueness
// flag. The block stalls the input while it works on a frame and takes the
// next one once the result sits in the output register.
// Output channel: one transfer per frame with all statistics. A result waits
// in the output register while the receiver stalls; a following frame is
// still taken and computed, and is held until the register frees up.
// Each frame takes two to four divisions (four while the window fills and
// the frame is unique) in one shared 53-step restoring divider; the block
// passes through idle between frames.
// Writing capture_rate restarts the measurement. Reset sets the rate to 60
// and clears all counters; ring slots not yet written since the restart read
// as zero through the frame count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module frame_rate_monitor #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration.
    input  logic                          i_cfg_we,
    input  logic [frm_pkg::RATE_W-1:0]    i_cfg_wdata,
    // Input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_unique_frame,
    // Output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [frm_pkg::ELAPSED_W-1:0] o_elapsed_us,
    output logic [frm_pkg::FPS_W-1:0]     o_current_fps_q8,
    output logic [frm_pkg::FPS_W-1:0]     o_average_fps_q8,
    output logic [frm_pkg::FT_W-1:0]      o_frame_time_us,
    output logic                          o_was_unique
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int PW = (AW > frm_pkg::RATE_W) ? AW : frm_pkg::RATE_W;

    // Effective rate: zero means the default, and the window caps it.
    function automatic logic [frm_pkg::RATE_W-1:0] f_eff_rate(
        input logic [frm_pkg::RATE_W-1:0] cap
    );
        logic [10:0] c;
        c = (cap == '0) ? 11'(frm_pkg::DEFAULT_RATE) : 11'(cap);
        if (int'(c) > MAX_WINDOW) begin
            c = 11'(MAX_WINDOW);
        end
        return frm_pkg::RATE_W'(c);
    endfunction

    // Control registers.
    frm_pkg::t_state r_state, n_state;
    frm_pkg::t_op    r_op, n_op;
    logic [frm_pkg::RATE_W-1:0] r_rate, n_rate;
    logic [PW-1:0]              r_wpos, n_wpos;
    logic [frm_pkg::RATE_W-1:0] r_wc, n_wc;
    logic [frm_pkg::CNT_W-1:0]  r_frames, n_frames;
    logic [frm_pkg::CNT_W-1:0]  r_unique, n_unique;
    logic [frm_pkg::RATE_W-1:0] r_zrun, n_zrun;
    logic                       r_seen, n_seen;
    logic                       r_out_valid, n_out_valid;

    // Per-frame working registers.
    logic [PW-1:0]                r_pos, n_pos;
    logic                         r_u, n_u;
    logic [frm_pkg::RATE_W-1:0]   r_z, n_z;
    logic                         r_fill, n_fill;
    logic [frm_pkg::DEN_W-1:0]    r_n1, n_n1;
    logic [frm_pkg::NUM_W-1:0]    r_prod, n_prod;
    logic [frm_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [frm_pkg::FPS_W-1:0]    r_cur, n_cur;
    logic [frm_pkg::FPS_W-1:0]    r_avg, n_avg;
    logic [frm_pkg::FT_W-1:0]     r_ft, n_ft;

    // Output payload registers.
    logic [frm_pkg::ELAPSED_W-1:0] r_out_elapsed, n_out_elapsed;
    logic [frm_pkg::FPS_W-1:0]     r_out_cur, n_out_cur;
    logic [frm_pkg::FPS_W-1:0]     r_out_avg, n_out_avg;
    logic [frm_pkg::FT_W-1:0]      r_out_ft, n_out_ft;
    logic                          r_out_u, n_out_u;

    // Datapath wires.
    logic [PW-1:0]                pos_now;
    logic [PW-1:0]                pos_inc;
    logic [frm_pkg::RATE_W-1:0]   rate_m1;
    logic                         old_flag;
    logic [frm_pkg::RATE_W-1:0]   wc_new;
    logic [frm_pkg::MUL_A_W-1:0]  mul_a;
    logic [frm_pkg::MUL_B_W-1:0]  mul_b;
    logic                         mul_scale;
    logic [frm_pkg::NUM_W-1:0]    mul_p;
    logic [frm_pkg::DEN_W-1:0]    div_den;
    logic [frm_pkg::NUM_W-1:0]    div_num;
    logic [frm_pkg::NUM_W-1:0]    div_quo;
    frm_pkg::t_div_stat           div_stat;
    logic                         div_start;
    logic                         ram_re;
    logic                         ram_we;
    logic [0:0]                   ram_rdata;

    // Ring of uniqueness flags.
    frm_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (r_u),
        .i_re    (ram_re),
        .i_raddr (pos_now[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Shared divider.
    frm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_stat  (div_stat)
    );

    // Ring position and window bookkeeping.
    always_comb begin
        pos_now  = (r_wpos < PW'(r_rate)) ? r_wpos : '0;
        pos_inc  = r_pos + PW'(1);
        rate_m1  = r_rate - frm_pkg::RATE_W'(1);
        // A slot not written since the restart reads as zero.
        old_flag = (r_frames > frm_pkg::CNT_W'(r_pos)) & ram_rdata[0];
        wc_new   = r_wc - frm_pkg::RATE_W'(old_flag) + frm_pkg::RATE_W'(r_u);
    end

    // Operand selection for the shared multiplier and divider.
    always_comb begin
        mul_a     = r_n1;
        mul_b     = frm_pkg::US_PER_SEC;
        mul_scale = 1'b0;
        div_den   = frm_pkg::DEN_W'(r_rate);
        case (r_op)
            frm_pkg::OP_EL: begin
                mul_a   = r_n1;
                mul_b   = frm_pkg::US_PER_SEC;
                div_den = frm_pkg::DEN_W'(r_rate);
            end
            frm_pkg::OP_CUR: begin
                mul_a     = frm_pkg::MUL_A_W'(r_wc);
                mul_b     = frm_pkg::MUL_B_W'(r_rate);
                mul_scale = 1'b1;
                div_den   = r_n1;
            end
            frm_pkg::OP_AVG: begin
                mul_a     = frm_pkg::MUL_A_W'(r_unique);
                mul_b     = frm_pkg::MUL_B_W'(r_rate);
                mul_scale = 1'b1;
                div_den   = r_n1;
            end
            frm_pkg::OP_FT: begin
                mul_a   = frm_pkg::MUL_A_W'(r_z) + frm_pkg::MUL_A_W'(1);
                mul_b   = frm_pkg::US_PER_SEC;
                div_den = frm_pkg::DEN_W'(r_rate);
            end
            default: begin
                mul_a = r_n1;
            end
        endcase
        mul_p   = mul_a * mul_b;
        // Round to nearest: add half the divisor before dividing.
        div_num = r_prod + frm_pkg::NUM_W'(div_den >> 1);
    end

    // Sequencer: next state and next register values.
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_rate        = r_rate;
        n_wpos        = r_wpos;
        n_wc          = r_wc;
        n_frames      = r_frames;
        n_unique      = r_unique;
        n_zrun        = r_zrun;
        n_seen        = r_seen;
        n_out_valid   = r_out_valid;
        n_pos         = r_pos;
        n_u           = r_u;
        n_z           = r_z;
        n_fill        = r_fill;
        n_n1          = r_n1;
        n_prod        = r_prod;
        n_elapsed     = r_elapsed;
        n_cur         = r_cur;
        n_avg         = r_avg;
        n_ft          = r_ft;
        n_out_elapsed = r_out_elapsed;
        n_out_cur     = r_out_cur;
        n_out_avg     = r_out_avg;
        n_out_ft      = r_out_ft;
        n_out_u       = r_out_u;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        div_start     = 1'b0;

        // Output register drains on a transfer.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // A rate write restarts the measurement.
        if (i_cfg_we) begin
            n_rate   = f_eff_rate(i_cfg_wdata);
            n_wpos   = '0;
            n_wc     = '0;
            n_frames = '0;
            n_unique = '0;
            n_zrun   = '0;
            n_seen   = 1'b0;
        end

        case (r_state)
            frm_pkg::S_IDLE: begin
                // Take a frame and fetch the flag it replaces.
                if (i_in_valid) begin
                    n_u     = i_unique_frame;
                    n_pos   = pos_now;
                    ram_re  = 1'b1;
                    n_state = frm_pkg::S_UPDATE;
                end
            end
            frm_pkg::S_UPDATE: begin
                ram_we = 1'b1;
                n_wc   = wc_new;
                n_cur  = {wc_new, {frm_pkg::FRAC_BITS{1'b0}}};
                n_ft   = '0;
                if (r_u && (r_unique != '1)) begin
                    n_unique = r_unique + frm_pkg::CNT_W'(1);
                end
                // Zeros back to the last unique frame, capped below the rate.
                if (r_seen && (r_zrun < rate_m1)) begin
                    n_z = r_zrun;
                end else begin
                    n_z = rate_m1;
                end
                if (r_u) begin
                    n_zrun = '0;
                    n_seen = 1'b1;
                end else if (r_zrun != '1) begin
                    n_zrun = r_zrun + frm_pkg::RATE_W'(1);
                end
                n_fill = (r_frames < frm_pkg::CNT_W'(r_rate));
                n_n1   = frm_pkg::DEN_W'(r_frames) + frm_pkg::DEN_W'(1);
                if (r_frames != '1) begin
                    n_frames = r_frames + frm_pkg::CNT_W'(1);
                end
                n_wpos  = (pos_inc == PW'(r_rate)) ? '0 : pos_inc;
                n_op    = frm_pkg::OP_EL;
                n_state = frm_pkg::S_MUL;
            end
            frm_pkg::S_MUL: begin
                n_prod  = mul_scale ? (mul_p << frm_pkg::FRAC_BITS) : mul_p;
                n_state = frm_pkg::S_LOAD;
            end
            frm_pkg::S_LOAD: begin
                div_start = 1'b1;
                n_state   = frm_pkg::S_DIV;
            end
            frm_pkg::S_DIV: begin
                // Store the saturated quotient and pick the next quantity.
                if (div_stat.done) begin
                    case (r_op)
                        frm_pkg::OP_EL: begin
                            n_elapsed = (|div_quo[frm_pkg::NUM_W-1:frm_pkg::ELAPSED_W])
                                        ? '1 : div_quo[frm_pkg::ELAPSED_W-1:0];
                            n_op      = r_fill ? frm_pkg::OP_CUR : frm_pkg::OP_AVG;
                            n_state   = frm_pkg::S_MUL;
                        end
                        frm_pkg::OP_CUR: begin
                            n_cur   = (|div_quo[frm_pkg::NUM_W-1:frm_pkg::FPS_W])
                                      ? '1 : div_quo[frm_pkg::FPS_W-1:0];
                            n_op    = frm_pkg::OP_AVG;
                            n_state = frm_pkg::S_MUL;
                        end
                        frm_pkg::OP_AVG: begin
                            n_avg = (|div_quo[frm_pkg::NUM_W-1:frm_pkg::FPS_W])
                                    ? '1 : div_quo[frm_pkg::FPS_W-1:0];
                            if (r_u) begin
                                n_op    = frm_pkg::OP_FT;
                                n_state = frm_pkg::S_MUL;
                            end else begin
                                n_state = frm_pkg::S_FINISH;
                            end
                        end
                        frm_pkg::OP_FT: begin
                            n_ft    = (|div_quo[frm_pkg::NUM_W-1:frm_pkg::FT_W])
                                      ? '1 : div_quo[frm_pkg::FT_W-1:0];
                            n_state = frm_pkg::S_FINISH;
                        end
                        default: begin
                            n_state = frm_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            frm_pkg::S_FINISH: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_elapsed = r_elapsed;
                    n_out_cur     = r_cur;
                    n_out_avg     = r_avg;
                    n_out_ft      = r_ft;
                    n_out_u       = r_u;
                    n_state       = frm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frm_pkg::S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frm_pkg::S_IDLE;
            r_op        <= frm_pkg::OP_EL;
            r_rate      <= f_eff_rate(frm_pkg::DEFAULT_RATE);
            r_wpos      <= '0;
            r_wc        <= '0;
            r_frames    <= '0;
            r_unique    <= '0;
            r_zrun      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_rate      <= n_rate;
            r_wpos      <= n_wpos;
            r_wc        <= n_wc;
            r_frames    <= n_frames;
            r_unique    <= n_unique;
            r_zrun      <= n_zrun;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_pos         <= n_pos;
        r_u           <= n_u;
        r_z           <= n_z;
        r_fill        <= n_fill;
        r_n1          <= n_n1;
        r_prod        <= n_prod;
        r_elapsed     <= n_elapsed;
        r_cur         <= n_cur;
        r_avg         <= n_avg;
        r_ft          <= n_ft;
        r_out_elapsed <= n_out_elapsed;
        r_out_cur     <= n_out_cur;
        r_out_avg     <= n_out_avg;
        r_out_ft      <= n_out_ft;
        r_out_u       <= n_out_u;
    end

    // Ports.
    assign o_in_stall       = (r_state != frm_pkg::S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_elapsed_us     = r_out_elapsed;
    assign o_current_fps_q8 = r_out_cur;
    assign o_average_fps_q8 = r_out_avg;
    assign o_frame_time_us  = r_out_ft;
    assign o_was_unique     = r_out_u;

    // Assertions.
    `ASSERT_ALWAYS(a_wc_le_rate, i_clk, i_rst_n, r_wc <= r_rate,
        "window count exceeds the ring length")
    `ASSERT_ALWAYS(a_wpos_in_ring, i_clk, i_rst_n, r_wpos < PW'(r_rate),
        "write position outside the ring")
    `ASSERT_IMPLIES(a_done_in_div, i_clk, i_rst_n, div_stat.done,
        r_state == frm_pkg::S_DIV, "divider finished outside the wait state")
    `ASSERT_IMPLIES(a_start_idle_div, i_clk, i_rst_n, r_state == frm_pkg::S_LOAD,
        !div_stat.busy, "divider started while busy")
    `ASSERT_NEXT(a_finish_loads, i_clk, i_rst_n,
        (r_state == frm_pkg::S_FINISH) && (!r_out_valid || !i_out_stall),
        r_out_valid && (r_state == frm_pkg::S_IDLE), "finished result not presented")
    `ASSERT_IMPLIES(a_ft_only_unique, i_clk, i_rst_n, r_out_valid,
        (r_out_ft == '0) || r_out_u, "frame time on a repeated frame")

endmodule

// ===== hw/rtl/frm_ram.sv =====
// ----------------------------------------------------------------------------
// frm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/frm_div.sv =====
// ----------------------------------------------------------------------------
// frm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [frm_pkg::NUM_W-1:0]  i_num,
    input  logic [frm_pkg::DEN_W-1:0]  i_den,
    output logic [frm_pkg::NUM_W-1:0]  o_quo,
    output frm_pkg::t_div_stat         o_stat
);

    logic [frm_pkg::NUM_W-1:0]     r_quo;
    logic [frm_pkg::DEN_W-1:0]     r_rem;
    logic [frm_pkg::DEN_W-1:0]     r_den;
    logic [frm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [frm_pkg::DEN_W:0] trial;
    logic [frm_pkg::DEN_W:0] diff;
    logic                    ge;
    logic                    last;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb begin
        trial = {r_rem, r_quo[frm_pkg::NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        last  = (r_cnt == frm_pkg::DIV_CNT_W'(frm_pkg::NUM_W - 1));
    end

    // Control: busy while quotient bits remain, done pulse after the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + frm_pkg::DIV_CNT_W'(1);
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: the numerator shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[frm_pkg::DEN_W-1:0] : trial[frm_pkg::DEN_W-1:0];
            r_quo <= {r_quo[frm_pkg::NUM_W-2:0], ge};
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
